/* hw/rtl/tts_pkg.sv */
// Shared types, character codes and helper functions for the title text simplifier.
// Used by title_text_simplifier; depends on nothing else.

package tts_pkg;

   // Result queue sizing: one accepted beat pushes at most three results
   localparam int unsigned FIFO_DEPTH  = 8;
   localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W       = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned MAX_PUSH    = 3;
   localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(FIFO_DEPTH - MAX_PUSH);

   // Register indexes on the configuration port
   localparam logic REG_BRACKETS_ON = 1'b0;
   localparam logic REG_URL_MODE    = 1'b1;

   // Character codes
   localparam logic [15:0] CH_SPACE   = 16'h0020;
   localparam logic [15:0] CH_TAB     = 16'h0009;
   localparam logic [15:0] CH_LF      = 16'h000A;
   localparam logic [15:0] CH_CR      = 16'h000D;
   localparam logic [15:0] CH_LPAREN  = 16'h0028;
   localparam logic [15:0] CH_RPAREN  = 16'h0029;
   localparam logic [15:0] CH_LBRACE  = 16'h007B;
   localparam logic [15:0] CH_RBRACE  = 16'h007D;
   localparam logic [15:0] CH_LBRACK  = 16'h005B;
   localparam logic [15:0] CH_RBRACK  = 16'h005D;
   localparam logic [15:0] CH_APOS    = 16'h0027;
   localparam logic [15:0] CH_PERCENT = 16'h0025;
   localparam logic [15:0] CH_AMP     = 16'h0026;
   localparam logic [15:0] CH_EM_DASH = 16'h2014;
   localparam logic [15:0] CH_EN_DASH = 16'h2013;
   localparam logic [15:0] CH_ACUTE   = 16'h00B4;
   localparam logic [15:0] CH_DEGREE  = 16'h00B0;
   localparam logic [15:0] CH_TM      = 16'h2122;
   localparam logic [15:0] CH_REG     = 16'h00AE;
   localparam logic [15:0] CH_DOT     = 16'h002E;
   localparam logic [15:0] CH_DASH    = 16'h002D;

   // Closer codes of an open bracketed span
   localparam logic [1:0] CLOSE_PAREN = 2'd0;
   localparam logic [1:0] CLOSE_BRACE = 2'd1;
   localparam logic [1:0] CLOSE_BRACK = 2'd2;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic        unit_valid;
      logic        end_of_text;
   } rsp_type;

   // One-unit hold of the dot/dash trimming stage
   typedef struct packed {
      logic [15:0] unit;
      logic        valid;
      logic        at_start;
   } hold_type;

   typedef struct packed {
      hold_type    hold;
      logic        emit;
      logic [15:0] unit;
   } feed_type;

   function automatic logic is_dot_or_dash(logic [15:0] c);
      return (c == CH_DOT) || (c == CH_DASH);
   endfunction

   function automatic logic [15:0] closer_char(logic [1:0] code);
      logic [15:0] r;
      case (code)
         CLOSE_PAREN: r = CH_RPAREN;
         CLOSE_BRACE: r = CH_RBRACE;
         default:     r = CH_RBRACK;
      endcase
      return r;
   endfunction

   // Whitespace and the punctuation that collapses into a single space
   function automatic logic is_skippable(logic [15:0] c, logic url);
      logic base;
      logic extra;
      base = c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR,
                       16'h003B, 16'h002C, 16'h003A, 16'h005E, 16'h007E, 16'h0022,
                       16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h002F, 16'h005C,
                       16'h003C, 16'h003E, 16'h007C, 16'h003D, 16'h002B, 16'h003F,
                       16'h002A, 16'h005F, 16'h0060,
                       CH_LPAREN, CH_LBRACE, CH_LBRACK, CH_RPAREN, CH_RBRACE, CH_RBRACK,
                       CH_EM_DASH, CH_EN_DASH, CH_ACUTE, CH_DEGREE, CH_TM, CH_REG};
      extra = url && (c inside {CH_APOS, CH_PERCENT, CH_AMP});
      return base || extra;
   endfunction

   // Push one simplified unit through the hold; may release the held unit
   function automatic feed_type feed(hold_type h, logic [15:0] c);
      feed_type r;
      logic     dd;
      logic     after;
      logic     skip;
      dd      = is_dot_or_dash(h.unit);
      after   = (c == CH_SPACE);
      skip    = dd && h.at_start && after;
      r.hold  = h;
      r.unit  = h.unit;
      r.emit  = 1'b0;
      if (h.valid) begin
         r.emit = !(dd && (h.at_start || after));
         if (skip) begin
            // swallow the space that follows a lone dot or dash
            r.hold.valid    = 1'b0;
            r.hold.at_start = 1'b1;
         end else begin
            r.hold.at_start = (h.unit == CH_SPACE);
            r.hold.unit     = c;
            r.hold.valid    = 1'b1;
         end
      end else begin
         r.hold.unit  = c;
         r.hold.valid = 1'b1;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/title_text_simplifier.sv */
// Top level of the title text simplifier: bracket stripping, run collapsing,
// dot/dash trimming and an eight-entry result queue. Depends on tts_pkg.
//
// Usage:
//  - req channel: one UTF-16 code unit per beat, with last on the title's
//    final unit. rsp channel: result beats (out_unit, unit_valid,
//    end_of_text); the final beat of a title has end_of_text set, and a title
//    that simplifies to nothing gives one beat with unit_valid low.
//  - csr port (APB style, pready tied high): register 0 at address 0 is
//    brackets_on, register 1 at address 4 is url_mode. Write only while idle.
//  - Every accepted beat is processed in the accept cycle and pushes zero to
//    three results into the queue; they show on rsp from the next cycle at the
//    earliest. A character leaves once its successor (or last) is seen, since
//    one unit is held for dot/dash trimming.
//  - Throughput: one code unit per cycle. req_ready drops when the queue
//    holds more than five results, since a beat may push three.
//  - When the receiver stalls, results wait in the queue and the input side
//    keeps going until the queue fills.
//  - Reset clears registers, title state and the queue.

module title_text_simplifier (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tts_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tts_pkg::rsp_type    rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   // Configuration registers
   logic brackets_on_ff, brackets_on_in;
   logic url_mode_ff, url_mode_in;

   // Title state
   logic              in_span_ff, in_span_in;
   logic [1:0]        span_closer_ff, span_closer_in;
   logic              kept_any_ff, kept_any_in;
   logic              run_pending_ff, run_pending_in;
   tts_pkg::hold_type hold_ff, hold_in;

   // Result queue
   tts_pkg::rsp_type              fifo_ff [tts_pkg::FIFO_DEPTH];
   tts_pkg::rsp_type              fifo_in [tts_pkg::FIFO_DEPTH];
   logic [tts_pkg::PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tts_pkg::PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tts_pkg::CNT_W-1:0]     count_ff, count_in;

   logic              accept;
   logic              pop;
   logic              csr_write;
   logic              csr_index;
   logic              span;
   logic [1:0]        closer;
   logic              pass;
   logic              keep;
   logic              en_space;
   tts_pkg::feed_type f_space;
   tts_pkg::feed_type f_unit;
   tts_pkg::hold_type hold_a;
   tts_pkg::hold_type hold_b;
   logic              final_emit;
   logic              v0, v1, v2;
   tts_pkg::rsp_type  e0, e1, e2;
   logic [tts_pkg::PTR_W-1:0] p1, p2;
   logic [1:0]        push_n;

   // Handshakes
   assign accept     = req_valid && req_ready;
   assign pop        = rsp_valid && rsp_ready;
   assign req_ready  = (count_ff <= tts_pkg::READY_LIMIT);
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = fifo_ff[rd_ptr_ff];

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      brackets_on_in = brackets_on_ff;
      url_mode_in    = url_mode_ff;
      if (csr_write) begin
         case (csr_index)
            tts_pkg::REG_BRACKETS_ON: brackets_on_in = csr_pwdata[0];
            tts_pkg::REG_URL_MODE:    url_mode_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tts_pkg::REG_BRACKETS_ON: csr_prdata = {31'd0, brackets_on_ff};
         tts_pkg::REG_URL_MODE:    csr_prdata = {31'd0, url_mode_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // Bracket stage: when brackets_on is set, open a span on an opener, close it on its own closer
   always_comb begin
      span   = in_span_ff;
      closer = span_closer_ff;
      pass   = 1'b1;
      if (brackets_on_ff) begin
         if (!span) begin
            if (req_data.code_unit == tts_pkg::CH_LPAREN) begin
               span   = 1'b1;
               closer = tts_pkg::CLOSE_PAREN;
            end else if (req_data.code_unit == tts_pkg::CH_LBRACE) begin
               span   = 1'b1;
               closer = tts_pkg::CLOSE_BRACE;
            end else if (req_data.code_unit == tts_pkg::CH_LBRACK) begin
               span   = 1'b1;
               closer = tts_pkg::CLOSE_BRACK;
            end
         end
         if (span) begin
            pass = 1'b0;
            if (req_data.code_unit == tts_pkg::closer_char(closer)) begin
               span = 1'b0;
            end
         end
      end
   end

   // Collapse stage and dot/dash hold: a pending space, then the unit itself
   assign keep     = pass && !tts_pkg::is_skippable(req_data.code_unit, url_mode_ff);
   assign en_space = keep && run_pending_ff;
   assign f_space  = tts_pkg::feed(hold_ff, tts_pkg::CH_SPACE);
   assign hold_a   = en_space ? f_space.hold : hold_ff;
   assign f_unit   = tts_pkg::feed(hold_a, req_data.code_unit);
   assign hold_b   = keep ? f_unit.hold : hold_a;

   // Gather up to three results and mark the final one
   always_comb begin
      final_emit = req_data.last && hold_b.valid && !tts_pkg::is_dot_or_dash(hold_b.unit);
      v0 = en_space && f_space.emit;
      v1 = keep && f_unit.emit;
      v2 = final_emit || (req_data.last && !v0 && !v1);
      e0.out_unit      = f_space.unit;
      e0.unit_valid    = 1'b1;
      e0.end_of_text   = req_data.last && !v1 && !v2;
      e1.out_unit      = f_unit.unit;
      e1.unit_valid    = 1'b1;
      e1.end_of_text   = req_data.last && !v2;
      e2.out_unit      = final_emit ? hold_b.unit : 16'h0000;
      e2.unit_valid    = final_emit;
      e2.end_of_text   = 1'b1;
      p1     = wr_ptr_ff + tts_pkg::PTR_W'(v0);
      p2     = p1 + tts_pkg::PTR_W'(v1);
      push_n = accept ? (2'(v0) + 2'(v1) + 2'(v2)) : 2'd0;
   end

   // Queue update
   always_comb begin
      fifo_in = fifo_ff;
      if (accept) begin
         if (v0) fifo_in[wr_ptr_ff] = e0;
         if (v1) fifo_in[p1]        = e1;
         if (v2) fifo_in[p2]        = e2;
      end
      wr_ptr_in = wr_ptr_ff + tts_pkg::PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + tts_pkg::PTR_W'(pop);
      count_in  = count_ff + tts_pkg::CNT_W'(push_n) - tts_pkg::CNT_W'(pop);
   end

   // Title state update; drop back to reset values after the last unit
   always_comb begin
      in_span_in     = in_span_ff;
      span_closer_in = span_closer_ff;
      kept_any_in    = kept_any_ff;
      run_pending_in = run_pending_ff;
      hold_in        = hold_ff;
      if (accept) begin
         if (req_data.last) begin
            in_span_in     = 1'b0;
            span_closer_in = tts_pkg::CLOSE_PAREN;
            kept_any_in    = 1'b0;
            run_pending_in = 1'b0;
            hold_in        = '{unit: 16'h0000, valid: 1'b0, at_start: 1'b1};
         end else begin
            in_span_in     = span;
            span_closer_in = closer;
            hold_in        = hold_b;
            if (keep) begin
               kept_any_in    = 1'b1;
               run_pending_in = 1'b0;
            end else if (pass && kept_any_ff) begin
               run_pending_in = 1'b1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brackets_on_ff <= 1'b0;
         url_mode_ff    <= 1'b0;
         in_span_ff     <= 1'b0;
         span_closer_ff <= tts_pkg::CLOSE_PAREN;
         kept_any_ff    <= 1'b0;
         run_pending_ff <= 1'b0;
         hold_ff        <= '{unit: 16'h0000, valid: 1'b0, at_start: 1'b1};
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         brackets_on_ff <= brackets_on_in;
         url_mode_ff    <= url_mode_in;
         in_span_ff     <= in_span_in;
         span_closer_ff <= span_closer_in;
         kept_any_ff    <= kept_any_in;
         run_pending_ff <= run_pending_in;
         hold_ff        <= hold_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   // Queue payload, no reset
   always_ff @(posedge clock) begin
      fifo_ff <= fifo_in;
   end

endmodule

/* sim/title_text_simplifier_test.sv */
// Self-checking testbench for title_text_simplifier: directed and random titles on the
// req channel, results checked beat by beat against a built-in title predictor.
// Depends on tts_pkg and title_text_simplifier.

module title_text_simplifier_test;

   localparam logic [2:0] ADDR_BRACKETS_ON = {tts_pkg::REG_BRACKETS_ON, 2'b00};
   localparam logic [2:0] ADDR_URL_MODE    = {tts_pkg::REG_URL_MODE, 2'b00};
   localparam int         PHASE_UNITS      = 10;

   // Punctuation that collapses into a space in every mode
   localparam logic [15:0] PUNCT [21] = '{16'h003B, 16'h002C, 16'h003A, 16'h005E, 16'h007E,
                                          16'h0022, 16'h0021, 16'h0040, 16'h0023, 16'h0024,
                                          16'h002F, 16'h005C, 16'h003C, 16'h003E, 16'h007C,
                                          16'h003D, 16'h002B, 16'h003F, 16'h002A, 16'h005F,
                                          16'h0060};
   localparam logic [15:0] BRACKETS [6] = '{tts_pkg::CH_LPAREN, tts_pkg::CH_RPAREN,
                                            tts_pkg::CH_LBRACE, tts_pkg::CH_RBRACE,
                                            tts_pkg::CH_LBRACK, tts_pkg::CH_RBRACK};
   localparam logic [15:0] WIDE_MARKS [6] = '{tts_pkg::CH_EM_DASH, tts_pkg::CH_EN_DASH,
                                              tts_pkg::CH_ACUTE, tts_pkg::CH_DEGREE,
                                              tts_pkg::CH_TM, tts_pkg::CH_REG};
   localparam logic [15:0] URL_MARKS [3] = '{tts_pkg::CH_APOS, tts_pkg::CH_PERCENT,
                                             tts_pkg::CH_AMP};
   localparam logic [15:0] WHITE [4] = '{tts_pkg::CH_SPACE, tts_pkg::CH_TAB, tts_pkg::CH_LF,
                                         tts_pkg::CH_CR};

   // Predicts the simplified title and holds the result beats still to come
   class title_tracker;
      logic             brackets_on;
      logic             url_mode;
      logic             in_span;
      logic [1:0]       closer_code;
      logic             kept_any;
      logic             run_pending;
      logic [15:0]      held_unit;
      logic             held_valid;
      logic             held_at_start;
      tts_pkg::rsp_type coming_units[$];
      int               failures;

      function new();
         brackets_on = 1'b0;
         url_mode    = 1'b0;
         failures    = 0;
         clear_title();
      endfunction

      function void clear_title();
         in_span       = 1'b0;
         closer_code   = tts_pkg::CLOSE_PAREN;
         kept_any      = 1'b0;
         run_pending   = 1'b0;
         held_unit     = '0;
         held_valid    = 1'b0;
         held_at_start = 1'b1;
      endfunction

      function bit collapses(logic [15:0] c);
         bit hit;
         hit = 1'b0;
         foreach (WHITE[i]) if (c == WHITE[i]) hit = 1'b1;
         foreach (PUNCT[i]) if (c == PUNCT[i]) hit = 1'b1;
         foreach (BRACKETS[i]) if (c == BRACKETS[i]) hit = 1'b1;
         foreach (WIDE_MARKS[i]) if (c == WIDE_MARKS[i]) hit = 1'b1;
         if (url_mode) foreach (URL_MARKS[i]) if (c == URL_MARKS[i]) hit = 1'b1;
         return hit;
      endfunction

      function bit trims(logic [15:0] c);
         return (c == tts_pkg::CH_DOT) || (c == tts_pkg::CH_DASH);
      endfunction

      function void put_char(logic [15:0] c);
         tts_pkg::rsp_type beat;
         beat.out_unit    = c;
         beat.unit_valid  = 1'b1;
         beat.end_of_text = 1'b0;
         coming_units = {coming_units, beat};
      endfunction

      // Pass one unit of the collapsed text through the one-unit dot/dash hold
      function void hold_unit(logic [15:0] c);
         bit dd;
         bit after;
         if (held_valid) begin
            dd    = trims(held_unit);
            after = (c == tts_pkg::CH_SPACE);
            if (!(dd && (held_at_start || after))) put_char(held_unit);
            if (dd && held_at_start && after) begin
               // lone dot or dash: swallow the space behind it as well
               held_valid    = 1'b0;
               held_at_start = 1'b1;
               return;
            end
            held_at_start = (held_unit == tts_pkg::CH_SPACE);
         end
         held_unit  = c;
         held_valid = 1'b1;
      endfunction

      function void note_unit(tts_pkg::req_type beat);
         logic [15:0]      c;
         logic [15:0]      closer;
         bit               pass;
         int               made;
         tts_pkg::rsp_type tail;
         c    = beat.code_unit;
         pass = 1'b1;
         made = coming_units.size();
         // drop bracketed spans, first matching closer ends the span
         if (brackets_on) begin
            if (!in_span) begin
               if (c == tts_pkg::CH_LPAREN) begin
                  in_span = 1'b1;
                  closer_code = tts_pkg::CLOSE_PAREN;
               end else if (c == tts_pkg::CH_LBRACE) begin
                  in_span = 1'b1;
                  closer_code = tts_pkg::CLOSE_BRACE;
               end else if (c == tts_pkg::CH_LBRACK) begin
                  in_span = 1'b1;
                  closer_code = tts_pkg::CLOSE_BRACK;
               end
            end
            if (in_span) begin
               case (closer_code)
                  tts_pkg::CLOSE_PAREN: closer = tts_pkg::CH_RPAREN;
                  tts_pkg::CLOSE_BRACE: closer = tts_pkg::CH_RBRACE;
                  default:              closer = tts_pkg::CH_RBRACK;
               endcase
               pass = 1'b0;
               if (c == closer) in_span = 1'b0;
            end
         end
         // collapse runs into one space, drop leading runs
         if (pass) begin
            if (collapses(c)) begin
               if (kept_any) run_pending = 1'b1;
            end else begin
               if (run_pending) hold_unit(tts_pkg::CH_SPACE);
               hold_unit(c);
               kept_any    = 1'b1;
               run_pending = 1'b0;
            end
         end
         // flush the hold and mark the final beat, or an end-only beat
         if (beat.last) begin
            if (held_valid && !trims(held_unit)) put_char(held_unit);
            if (coming_units.size() > made) begin
               tail = coming_units.pop_back();
               tail.end_of_text = 1'b1;
               coming_units = {coming_units, tail};
            end else begin
               tail.out_unit    = '0;
               tail.unit_valid  = 1'b0;
               tail.end_of_text = 1'b1;
               coming_units = {coming_units, tail};
            end
            clear_title();
         end
      endfunction

      function void check_beat(tts_pkg::rsp_type got);
         tts_pkg::rsp_type want;
         if (coming_units.size() == 0) begin
            $error("unexpected result beat: out_unit %h unit_valid %b end_of_text %b",
                   got.out_unit, got.unit_valid, got.end_of_text);
            failures++;
            return;
         end
         want = coming_units.pop_front();
         if (got.out_unit !== want.out_unit) begin
            $error("out_unit: expected %h, actual %h", want.out_unit, got.out_unit);
            failures++;
         end
         if (got.unit_valid !== want.unit_valid) begin
            $error("unit_valid: expected %b, actual %b", want.unit_valid, got.unit_valid);
            failures++;
         end
         if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %b, actual %b", want.end_of_text, got.end_of_text);
            failures++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   tts_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   tts_pkg::rsp_type rsp_data;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [2:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   title_tracker titles = new();
   bit           steady = 1'b0;
   int           hold_off_cycles = 0;
   int           units_sent = 0;

   title_text_simplifier DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short idles, now and then a long one
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [15:0] pick_unit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'h0061 + 16'($urandom_range(0, 25));
      if (r < 55) return WHITE[$urandom_range(0, 3)];
      if (r < 68) return ($urandom_range(0, 1) != 0) ? tts_pkg::CH_DOT : tts_pkg::CH_DASH;
      if (r < 78) return BRACKETS[$urandom_range(0, 5)];
      if (r < 86) return PUNCT[$urandom_range(0, 20)];
      if (r < 91) return URL_MARKS[$urandom_range(0, 2)];
      if (r < 95) return WIDE_MARKS[$urandom_range(0, 5)];
      return 16'($urandom_range(0, 65535));
   endfunction

   // Offer one beat, hold it until accepted, then maybe idle
   task automatic send_unit(logic [15:0] code, logic last);
      tts_pkg::req_type beat;
      int               gap;
      beat.code_unit = code;
      beat.last      = last;
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      titles.note_unit(beat);
      units_sent++;
      gap = 0;
      if (!steady && $urandom_range(0, 99) >= 60) gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(string s, bit close_title);
      for (int i = 0; i < s.len(); i++)
         send_unit(16'(s[i]), close_title && (i == s.len() - 1));
   endtask

   // Drop valid and wait until all expected beats are out and the pipe is quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (titles.coming_units.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_title();
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
         send_unit(pick_unit(), i == len - 1);
         // pause now and then until every pending result is out
         if (i < len - 1 && $urandom_range(0, 29) == 0) wait_idle();
      end
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_modes(logic brackets, logic url);
      wait_idle();
      csr_write(ADDR_BRACKETS_ON, 32'(brackets));
      titles.brackets_on = brackets;
      csr_write(ADDR_URL_MODE, 32'(url));
      titles.url_mode = url;
   endtask

   // Result side: check accepted beats, stall at random, honor long hold-offs
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) titles.check_beat(rsp_data);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 30) stall = pick_idle();
         end
      end
   end

   initial begin
      bit phase_brackets [5];
      bit phase_url [5];
      int phase_start;
      phase_brackets = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
      phase_url      = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single char, blank title, dots and dashes, extreme code units
      send_text("a", 1'b1);
      send_text(" ", 1'b1);
      send_text(" -a. - b-", 1'b1);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'h0000, 1'b1);

      // directed: every bracket kind, an unclosed span, change of mode inside a title
      set_modes(1'b1, 1'b1);
      send_text("(a)b{c}[d", 1'b1);
      send_text("(m", 1'b0);
      set_modes(1'b0, 1'b1);
      send_text(")n", 1'b1);

      // random titles across register settings
      for (int p = 0; p < 5; p++) begin
         set_modes(phase_brackets[p], phase_url[p]);
         steady = (p == 3);
         if (p == 2) begin
            // block the result side while the sender streams a long title
            steady = 1'b1;
            hold_off_cycles = 60;
            for (int i = 0; i < 16; i++) send_unit(16'h0041 + 16'(i), i == 15);
            steady = 1'b0;
         end
         phase_start = units_sent;
         while (units_sent - phase_start < PHASE_UNITS) send_random_title();
      end

      req_valid <= 1'b0;
      while (titles.coming_units.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (titles.failures == 0 && titles.coming_units.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
